// ===== rtl/dd_pkg.sv =====
// Shared types and constants for the duplicate detector.
// No dependencies; used by dd_scan and duplicate_detect_hash_set.
package dd_pkg;

  localparam int DD_CAPACITY = 256;  // default table depth
  localparam int VALUE_W     = 32;   // width of one stored value
  localparam int OUT_W       = 8;    // output tdata, padded to a whole byte

  // Outcome of one table scan, handed from the scanner to the top level.
  typedef struct packed {
    logic done;   // one-cycle pulse: the scan has finished
    logic found;  // the key matched a filled entry
  } dd_scan_res_t;

endpackage

// ===== rtl/dd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dd_scan.sv =====
// Table scanner: walks the filled entries one read a cycle through the shared
// comparator and reports whether the key is present. Depends on dd_pkg.
module dd_scan
  import dd_pkg::*;
#(
  parameter int CAPACITY = DD_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [VALUE_W-1:0]             key,
  input  logic [$clog2(CAPACITY+1)-1:0]  count,
  output logic                           rd_en,
  output logic [$clog2(CAPACITY)-1:0]    rd_addr,
  input  logic [VALUE_W-1:0]             rd_data,
  output dd_scan_res_t                   res
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } scan_state_t;

  scan_state_t      state;
  logic [CNT_W-1:0] ptr;
  logic             pend;
  logic             hit;

  // The read issued last cycle is compared now; ptr is the next entry to read.
  assign hit     = pend && (rd_data == key);
  assign rd_en   = (state == S_RUN) && (ptr != count) && !hit;
  assign rd_addr = ptr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      pend      <= 1'b0;
      res.done  <= 1'b0;
      res.found <= 1'b0;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ptr   <= '0;
            pend  <= 1'b0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (hit) begin
            res.done  <= 1'b1;
            res.found <= 1'b1;
            pend      <= 1'b0;
            state     <= S_IDLE;
          end else if (ptr == count) begin
            res.done  <= 1'b1;
            res.found <= 1'b0;
            pend      <= 1'b0;
            state     <= S_IDLE;
          end else begin
            ptr  <= ptr + CNT_W'(1);
            pend <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/duplicate_detect_hash_set.sv =====
// An accepted item is held while the scanner reads the values already stored in its
// set, ending early when one matches; the verdict then goes to the output register.
// The scanner reads one table entry per cycle from a single RAM port, and no new item
// is taken until the verdict is committed; a stalled output holds the next item off.
// Reset (synchronous, active high) empties the table, clears both sticky flags
// and drops any pending result; the RAM contents themselves are not cleared.
module duplicate_detect_hash_set
  import dd_pkg::*;
#(
  parameter int CAPACITY = DD_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  // Input items
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value (signed)
  input  logic               s_tlast,   // last: final value of the set
  // Result items
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // [0] seen_before, [1] has_duplicate,
                                        // [2] overflow, [7:3] zero
  output logic               m_tlast    // set_done
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // The control sequence: wait for an item, let the scanner walk the table,
  // then commit the verdict into the output register once that is free.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } st_t;

  st_t              state;
  logic [VALUE_W-1:0] key;
  logic             key_last;
  logic             found;
  logic [CNT_W-1:0] count;
  logic             dup_flag;
  logic             ovf_flag;

  logic             accept;
  logic             emit;
  logic             full;
  logic             insert;
  logic             dup_next;
  logic             ovf_next;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_data;
  dd_scan_res_t       scan_res;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // The verdict is committed only when the output register is empty or is
  // being emptied in this very cycle, so no result is ever overwritten.
  assign emit     = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // Entries are filled in order, so the fill count alone marks which slots
  // hold values of the current set.
  assign full     = (count == CNT_W'(CAPACITY));
  assign insert   = emit && !found && !full;
  assign dup_next = dup_flag || found;
  assign ovf_next = ovf_flag || (!found && full);

  dd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (insert),
    .waddr (count[IDX_W-1:0]),
    .wdata (key),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // The key and count registers hold steady for the whole scan, as no new
  // item is taken and no insert happens until the scan has finished.
  dd_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .key     (key),
    .count   (count),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .res     (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      dup_flag <= 1'b0;
      ovf_flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // A new verdict refills the output register; otherwise a taken result
      // leaves it empty.
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_res.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            state    <= ST_IDLE;
            // The last item of a set carries the final verdict and then
            // empties the table for the next set.
            if (key_last) begin
              count    <= '0;
              dup_flag <= 1'b0;
              ovf_flag <= 1'b0;
            end else begin
              dup_flag <= dup_next;
              ovf_flag <= ovf_next;
              if (insert) begin
                count <= count + CNT_W'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= s_tdata;
      key_last <= s_tlast;
    end
    if (scan_res.done) begin
      found <= scan_res.found;
    end
    if (emit) begin
      m_tdata <= {(OUT_W - 3)'(0), ovf_next, dup_next, found};
      m_tlast <= key_last;
    end
  end

  // A scan may only finish while the sequencer is waiting for it.
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_res.done |-> (state == ST_SCAN))
    else $error("scan finished outside the scan phase");

  // The fill count never goes beyond the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  // Committing the last item of a set leaves an empty table and clear flags.
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (emit && key_last) |=> (count == '0) && !dup_flag && !ovf_flag)
    else $error("table not cleared after end of set");

  // A value seen before always shows in the sticky duplicate flag.
  a_seen_implies_dup: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tdata[1])
    else $error("seen_before set without has_duplicate");

endmodule
